>>> src/converter_sample_lane_packer_defines.svh
// Assertion macros shared by the lane packer RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef CONVERTER_SAMPLE_LANE_PACKER_DEFINES_SVH
`define CONVERTER_SAMPLE_LANE_PACKER_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define CSLP_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define CSLP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/cslp_pkg.sv
// Constants, precision codes and widening helpers for the lane packer.
// No dependencies; used by the channel interfaces and the top level.
package cslp_pkg;

  localparam int BUFFER_WORDS = 4;
  localparam int LANE_W       = 64;
  localparam int BUF_BITS     = BUFFER_WORDS * LANE_W;
  localparam int CNT_W        = $clog2(BUF_BITS + 1);
  localparam int SAMPLE_W     = 16;
  localparam int WIDE_W       = 48;
  localparam int GW_W         = 6;
  localparam int MODE_W       = 3;

  // Precision codes; codes above MODE_48 act as 16 bits
  localparam logic [MODE_W-1:0] MODE_12 = 3'd0;
  localparam logic [MODE_W-1:0] MODE_16 = 3'd1;
  localparam logic [MODE_W-1:0] MODE_24 = 3'd2;
  localparam logic [MODE_W-1:0] MODE_32 = 3'd3;
  localparam logic [MODE_W-1:0] MODE_48 = 3'd4;

  typedef logic [MODE_W-1:0]   mode_t;
  typedef logic [SAMPLE_W-1:0] sample_t;
  typedef logic [LANE_W-1:0]   lane_t;

  // Nibble-group width in bits for a precision code
  function automatic logic [GW_W-1:0] group_width(input mode_t mode);
    logic [GW_W-1:0] w;
    unique case (mode)
      MODE_12: w = 6'd12;
      MODE_24: w = 6'd24;
      MODE_32: w = 6'd32;
      MODE_48: w = 6'd48;
      default: w = 6'd16;
    endcase
    return w;
  endfunction

  // Place the MSB-aligned converter word into its nibble group
  function automatic logic [WIDE_W-1:0] widen(input mode_t mode, input sample_t word);
    logic [WIDE_W-1:0] w;
    unique case (mode)
      MODE_12: w = {36'd0, word[15:4]};
      MODE_24: w = {24'd0, word, 8'd0};
      MODE_32: w = {16'd0, word, 16'd0};
      MODE_48: w = {word, 32'd0};
      default: w = {32'd0, word};
    endcase
    return w;
  endfunction

endpackage

>>> src/cslp_sample_if.sv
// Input channel: one converter word beat with its valid and end-of-column marks.
// Depends on cslp_pkg.
interface cslp_sample_if import cslp_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t sample_word;
  logic    sample_valid;
  logic    end_of_column;

  modport source (output valid, sample_word, sample_valid, end_of_column, input ready);
  modport sink   (input valid, sample_word, sample_valid, end_of_column, output ready);
endinterface

>>> src/cslp_lane_if.sv
// Output channel: one 64-bit lane word beat with the sticky overflow flag.
// Depends on cslp_pkg.
interface cslp_lane_if import cslp_pkg::*; ();
  logic  valid;
  logic  ready;
  lane_t lane_word;
  logic  overflow;

  modport source (output valid, lane_word, overflow, input ready);
  modport sink   (input valid, lane_word, overflow, output ready);
endinterface

>>> src/cslp_cfg_if.sv
// Configuration write channel carrying the precision register value.
// Depends on cslp_pkg.
interface cslp_cfg_if import cslp_pkg::*; ();
  logic  valid;
  logic  ready;
  mode_t precision_mode;

  modport source (output valid, precision_mode, input ready);
  modport sink   (input valid, precision_mode, output ready);
endinterface

>>> src/converter_sample_lane_packer.sv
// Channel     Dir  Payload
// sample      in   sample_word[15:0], sample_valid, end_of_column
// lane        out  lane_word[63:0], overflow
// cfg         in   precision_mode[2:0]
//
// Takes one sample beat per clock unless a stalled lane beat keeps the input
// register full; a lane beat is drained through the input register, then the
// result register. The 256-bit pack buffer and bit count update as a beat advances.
// rst is synchronous: buffer and count clear, precision returns to 16 bits.
// A stalled lane beat holds the buffer; the input register keeps accepting
// until it holds a beat that cannot advance.
// Depends on cslp_pkg, the channel interfaces and the assertion macros.
`include "converter_sample_lane_packer_defines.svh"

module converter_sample_lane_packer import cslp_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  cslp_sample_if.sink   sample,
  cslp_lane_if.source   lane,
  cslp_cfg_if.sink      cfg
);

  // Input register
  logic                in_full;
  sample_t             in_word;
  logic                in_svalid;
  logic                in_eoc;

  // Pack state
  logic [BUF_BITS-1:0] buffer;
  logic [CNT_W-1:0]    count;
  logic                overflow_seen;
  mode_t               precision;

  // Result register
  logic                out_valid;
  lane_t               out_word;
  logic                out_ovf;

  // Next-state logic
  logic                go;
  logic [GW_W-1:0]     gw;
  logic [WIDE_W-1:0]   wide;
  logic [CNT_W:0]      sum;
  logic                fits;
  logic                append;
  logic [BUF_BITS-1:0] shifted;
  logic [BUF_BITS-1:0] buf_app;
  logic [CNT_W-1:0]    cnt_app;
  logic                drain;
  logic [BUF_BITS-1:0] buffer_next;
  logic [CNT_W-1:0]    count_next;
  logic                overflow_next;

  // Advance the held beat when the result slot is free or being emptied
  assign go           = in_full && (!out_valid || lane.ready);
  assign sample.ready = !in_full || go;
  assign cfg.ready    = 1'b1;

  assign lane.valid     = out_valid;
  assign lane.lane_word = out_word;
  assign lane.overflow  = out_ovf;

  // Append the widened word at the fill level if it fits, then drain one lane word on end of column
  always_comb begin
    gw            = group_width(precision);
    wide          = widen(precision, in_word);
    sum           = {1'b0, count} + (CNT_W+1)'(gw);
    fits          = sum <= (CNT_W+1)'(BUF_BITS);
    append        = in_svalid && fits;
    overflow_next = overflow_seen | (in_svalid && !fits);
    shifted       = BUF_BITS'(wide) << count;
    buf_app       = append ? (buffer | shifted) : buffer;
    cnt_app       = append ? sum[CNT_W-1:0] : count;
    drain         = in_eoc && (cnt_app >= CNT_W'(LANE_W));
    buffer_next   = drain ? (buf_app >> LANE_W) : buf_app;
    count_next    = drain ? (cnt_app - CNT_W'(LANE_W)) : cnt_app;
  end

  // Hold control state, buffer and registered outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full       <= 1'b0;
      out_valid     <= 1'b0;
      buffer        <= '0;
      count         <= '0;
      overflow_seen <= 1'b0;
      precision     <= MODE_16;
    end else begin
      if (sample.valid && sample.ready) begin
        in_full <= 1'b1;
      end else if (go) begin
        in_full <= 1'b0;
      end

      if (go) begin
        buffer        <= buffer_next;
        count         <= count_next;
        overflow_seen <= overflow_next;
        out_valid     <= drain;
      end else if (lane.ready) begin
        out_valid <= 1'b0;
      end

      if (cfg.valid) begin
        precision <= cfg.precision_mode;
      end
    end
  end

  // Load payload registers
  always_ff @(posedge clk) begin
    if (sample.valid && sample.ready) begin
      in_word   <= sample.sample_word;
      in_svalid <= sample.sample_valid;
      in_eoc    <= sample.end_of_column;
    end
    if (go && drain) begin
      out_word <= buf_app[LANE_W-1:0];
      out_ovf  <= overflow_next;
    end
  end

  `CSLP_ASSERT_IMPL(a_count_range, clk, rst, 1'b1, count <= CNT_W'(BUF_BITS),
    "bit count beyond buffer capacity")
  `CSLP_ASSERT_IMPL(a_upper_clear, clk, rst, 1'b1, (buffer >> count) == '0,
    "buffer holds bits above the fill level")
  `CSLP_ASSERT_NEXT(a_overflow_sticky, clk, rst, overflow_seen, overflow_seen,
    "overflow flag cleared without reset")
  `CSLP_ASSERT_IMPL(a_out_ovf, clk, rst, out_valid && out_ovf, overflow_seen,
    "lane beat flags overflow the state never saw")
  `CSLP_ASSERT_NEXT(a_drain_emits, clk, rst, go && drain, out_valid,
    "drained lane word not presented")

endmodule

>>> verif/converter_sample_lane_packer_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for converter_sample_lane_packer: directed beats, then random columns.
// Expected lane beats come from a local bit-level packing model of the lane.
// Depends on cslp_pkg, the three channel interfaces and the packer top level.
module converter_sample_lane_packer_tb;
  import cslp_pkg::*;

  // Undefined precision codes, which pack as 16 bits
  localparam mode_t MODE_UNDEF_LO = 3'd5;
  localparam mode_t MODE_UNDEF_HI = 3'd7;

  localparam int DIR_ROWS  = 26;
  localparam int SEG_ITEMS = 100;
  localparam int HOLD_LEN  = 400;
  localparam int FLUSH_CYC = 6;

  typedef struct packed {
    lane_t word;
    logic  ovf;
  } lane_beat_t;

  // Per-beat tag: a typed expectation that replaces the model's result
  typedef struct packed {
    logic       typed;
    lane_beat_t res;
  } beat_tag_t;

  typedef struct packed {
    logic    set_mode;
    mode_t   mode;
    sample_t word;
    logic    sv;
    logic    eoc;
    logic    typed;
    lane_t   exp_word;
    logic    exp_ovf;
  } stim_row_t;

  logic clk;
  logic rst;

  cslp_sample_if sample_ch ();
  cslp_lane_if   lane_ch ();
  cslp_cfg_if    cfg_ch ();

  converter_sample_lane_packer dut (
    .clk    (clk),
    .rst    (rst),
    .sample (sample_ch),
    .lane   (lane_ch),
    .cfg    (cfg_ch)
  );

  // Packing model state
  logic [BUF_BITS-1:0] pack_q    = '0;
  int unsigned         fill_bits = 0;
  logic                ovf_seen  = 1'b0;
  mode_t               cur_mode  = MODE_16;

  lane_beat_t lane_exp_q [$];
  beat_tag_t  tag_q [$];
  beat_tag_t  cur_tag;
  lane_beat_t got_beat;
  lane_beat_t exp_beat;

  int    errors         = 0;
  int    items_sent     = 0;
  int    send_idle_pct  = 0;
  int    lane_stall_pct = 0;
  bit    hold_request   = 1'b0;
  int    hold_left      = 0;
  mode_t lane_mode      = MODE_16;

  stim_row_t dir_plan [0:DIR_ROWS-1] = '{
    // after reset: four 16-bit words fill one lane word
    '{1'b0, MODE_16, 16'hFFFF, 1'b1, 1'b0, 1'b0, 64'h0, 1'b0},
    '{1'b0, MODE_16, 16'h0000, 1'b1, 1'b0, 1'b0, 64'h0, 1'b0},
    '{1'b0, MODE_16, 16'hFFFF, 1'b1, 1'b0, 1'b0, 64'h0, 1'b0},
    '{1'b0, MODE_16, 16'h1234, 1'b1, 1'b1, 1'b1, 64'h1234_FFFF_0000_FFFF, 1'b0},
    // 12-bit groups of all ones, 8 bits left over
    '{1'b1, MODE_12, 16'hFFF0, 1'b1, 1'b0, 1'b0, 64'h0, 1'b0},
    '{1'b0, MODE_12, 16'hFFF0, 1'b1, 1'b0, 1'b0, 64'h0, 1'b0},
    '{1'b0, MODE_12, 16'hFFF0, 1'b1, 1'b0, 1'b0, 64'h0, 1'b0},
    '{1'b0, MODE_12, 16'hFFF0, 1'b1, 1'b0, 1'b0, 64'h0, 1'b0},
    '{1'b0, MODE_12, 16'hFFF0, 1'b1, 1'b0, 1'b0, 64'h0, 1'b0},
    '{1'b0, MODE_12, 16'hFFF0, 1'b1, 1'b1, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0},
    // invalid word with a drain request below 64 bits: no beat
    '{1'b0, MODE_12, 16'hABCD, 1'b0, 1'b1, 1'b0, 64'h0, 1'b0},
    // precision change keeps the 8 buffered bits
    '{1'b1, MODE_24, 16'h8001, 1'b1, 1'b0, 1'b0, 64'h0, 1'b0},
    '{1'b0, MODE_24, 16'h7FFE, 1'b1, 1'b0, 1'b0, 64'h0, 1'b0},
    '{1'b0, MODE_24, 16'hFFFF, 1'b1, 1'b1, 1'b0, 64'h0, 1'b0},
    '{1'b1, MODE_32, 16'h5A5A, 1'b1, 1'b1, 1'b0, 64'h0, 1'b0},
    '{1'b0, MODE_32, 16'hC3C3, 1'b1, 1'b0, 1'b0, 64'h0, 1'b0},
    // invalid word, drain still taken
    '{1'b0, MODE_32, 16'h0000, 1'b0, 1'b1, 1'b0, 64'h0, 1'b0},
    // undefined codes act as 16 bits
    '{1'b1, MODE_UNDEF_LO, 16'h0F0F, 1'b1, 1'b0, 1'b0, 64'h0, 1'b0},
    '{1'b1, MODE_UNDEF_HI, 16'hF0F0, 1'b1, 1'b1, 1'b0, 64'h0, 1'b0},
    '{1'b1, MODE_48, 16'hFFFF, 1'b1, 1'b0, 1'b0, 64'h0, 1'b0},
    '{1'b0, MODE_48, 16'hFFFF, 1'b1, 1'b1, 1'b0, 64'h0, 1'b0},
    // fill to 224 bits, then two words with no room, the second with a drain
    '{1'b0, MODE_48, 16'h0001, 1'b1, 1'b0, 1'b0, 64'h0, 1'b0},
    '{1'b0, MODE_48, 16'h8000, 1'b1, 1'b0, 1'b0, 64'h0, 1'b0},
    '{1'b0, MODE_48, 16'hFFFF, 1'b1, 1'b0, 1'b0, 64'h0, 1'b0},
    '{1'b0, MODE_48, 16'h0000, 1'b1, 1'b0, 1'b0, 64'h0, 1'b0},
    '{1'b0, MODE_48, 16'hFFFF, 1'b1, 1'b1, 1'b0, 64'h0, 1'b0}
  };

  function automatic int unsigned group_bits(input mode_t m);
    case (m)
      MODE_12: return 12;
      MODE_24: return 24;
      MODE_32: return 32;
      MODE_48: return 48;
      default: return 16;
    endcase
  endfunction

  function automatic logic [WIDE_W-1:0] widen_sample(input mode_t m, input sample_t w);
    logic [WIDE_W-1:0] x;
    x = {32'd0, w};
    case (m)
      MODE_12: return x >> 4;
      MODE_24: return x << 8;
      MODE_32: return x << 16;
      MODE_48: return x << 32;
      default: return x;
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t ns: %s", $realtime, msg);
    errors++;
  endtask

  // Append one accepted beat to the model, then drain 64 bits if asked and held
  task automatic pack_beat(input sample_t w, input logic sv, input logic eoc,
                           input beat_tag_t tag);
    int unsigned         gw;
    logic [BUF_BITS-1:0] wide;
    gw = group_bits(cur_mode);
    if (sv) begin
      if (fill_bits + gw > BUF_BITS) begin
        ovf_seen = 1'b1;
      end else begin
        wide = '0;
        wide[WIDE_W-1:0] = widen_sample(cur_mode, w);
        pack_q = pack_q | (wide << fill_bits);
        fill_bits = fill_bits + gw;
      end
    end
    if (eoc && fill_bits >= LANE_W) begin
      lane_exp_q.push_back(tag.typed ? tag.res : lane_beat_t'({pack_q[LANE_W-1:0], ovf_seen}));
      pack_q = pack_q >> LANE_W;
      fill_bits = fill_bits - LANE_W;
    end else if (tag.typed) begin
      lane_exp_q.push_back(tag.res);
    end
  endtask

  // Clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Check lane beats, track config writes, model accepted sample beats
  always @(posedge clk) begin
    if (!rst) begin
      if (lane_ch.valid && lane_ch.ready) begin
        got_beat = {lane_ch.lane_word, lane_ch.overflow};
        if (lane_exp_q.size() == 0) begin
          report_mismatch($sformatf("lane beat %h with nothing expected", lane_ch.lane_word));
        end else begin
          exp_beat = lane_exp_q.pop_front();
          if (got_beat.word !== exp_beat.word)
            report_mismatch($sformatf("lane_word %h, expected %h", got_beat.word,
                                      exp_beat.word));
          if (got_beat.ovf !== exp_beat.ovf)
            report_mismatch($sformatf("overflow %b, expected %b", got_beat.ovf,
                                      exp_beat.ovf));
        end
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        cur_mode = cfg_ch.precision_mode;
      end
      if (sample_ch.valid && sample_ch.ready) begin
        cur_tag = tag_q.pop_front();
        pack_beat(sample_ch.sample_word, sample_ch.sample_valid, sample_ch.end_of_column,
                  cur_tag);
      end
    end
  end

  // Lane receiver: random stalls, plus a long hold when requested
  initial begin
    lane_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        lane_ch.ready <= 1'b0;
      end else if (hold_request) begin
        hold_request = 1'b0;
        hold_left = HOLD_LEN;
        lane_ch.ready <= 1'b0;
      end else begin
        lane_ch.ready <= ($urandom_range(99) >= lane_stall_pct);
      end
    end
  end

  // Offer one sample beat after a random gap and hold it until accepted
  task automatic send_item(input sample_t w, input logic sv, input logic eoc,
                           input logic typed, input lane_t ew, input logic eo);
    while ($urandom_range(99) < send_idle_pct) begin
      sample_ch.valid <= 1'b0;
      @(posedge clk);
    end
    sample_ch.valid         <= 1'b1;
    sample_ch.sample_word   <= w;
    sample_ch.sample_valid  <= sv;
    sample_ch.end_of_column <= eoc;
    tag_q.push_back({typed, ew, eo});
    @(posedge clk);
    while (!sample_ch.ready) @(posedge clk);
    if (sv || eoc) items_sent++;
  endtask

  // Drop valid and wait until every beat is in and the pipeline has emptied
  task automatic wait_drained();
    sample_ch.valid <= 1'b0;
    while (lane_exp_q.size() != 0 || tag_q.size() != 0) @(posedge clk);
    repeat (FLUSH_CYC) @(posedge clk);
  endtask

  task automatic write_mode(input mode_t m);
    cfg_ch.valid          <= 1'b1;
    cfg_ch.precision_mode <= m;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    lane_mode = m;
  endtask

  // One column sized near one lane word; sometimes an invalid slot inside
  task automatic send_column();
    int unsigned gw;
    int unsigned k;
    sample_t     w;
    gw = group_bits(lane_mode);
    k = (LANE_W + gw - 1) / gw;
    if ($urandom_range(1) == 1) k = LANE_W / gw;
    for (int i = 0; i < k; i++) begin
      case ($urandom_range(7))
        0:       w = '0;
        1:       w = '1;
        default: w = sample_t'($urandom_range(16'hFFFF));
      endcase
      send_item(w, $urandom_range(15) != 0, i == k - 1, 1'b0, '0, 1'b0);
    end
  endtask

  task automatic send_random(input int n);
    int target;
    target = items_sent + n;
    while (items_sent < target) begin
      if ($urandom_range(7) == 0)
        send_item(sample_t'($urandom_range(16'hFFFF)), 1'($urandom_range(1)),
                  1'($urandom_range(1)), 1'b0, '0, 1'b0);
      else
        send_column();
    end
  endtask

  // Run limit
  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // Stimulus
  initial begin
    rst                     <= 1'b1;
    sample_ch.valid         <= 1'b0;
    sample_ch.sample_word   <= '0;
    sample_ch.sample_valid  <= 1'b0;
    sample_ch.end_of_column <= 1'b0;
    cfg_ch.valid            <= 1'b0;
    cfg_ch.precision_mode   <= MODE_16;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table; config writes only once the lane is idle
    for (int r = 0; r < DIR_ROWS; r++) begin
      if (dir_plan[r].set_mode) begin
        wait_drained();
        write_mode(dir_plan[r].mode);
      end
      send_item(dir_plan[r].word, dir_plan[r].sv, dir_plan[r].eoc, dir_plan[r].typed,
                dir_plan[r].exp_word, dir_plan[r].exp_ovf);
    end

    // Random phases: none, sender idle, receiver stall, both
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  lane_stall_pct = 0;  end
        1: begin send_idle_pct = 79; lane_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  lane_stall_pct = 79; end
        default: begin send_idle_pct = 11; lane_stall_pct = 11; end
      endcase
      for (int seg = 0; seg < 4; seg++) begin
        wait_drained();
        write_mode(mode_t'($urandom_range(7)));
        send_random(SEG_ITEMS);
      end
    end

    // Long receiver hold with a steady sender, so the input backs up
    send_idle_pct = 0;
    lane_stall_pct = 0;
    wait_drained();
    write_mode(MODE_12);
    hold_request = 1'b1;
    send_random(HOLD_LEN);

    wait_drained();
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+src
src/cslp_pkg.sv
src/cslp_sample_if.sv
src/cslp_lane_if.sv
src/cslp_cfg_if.sv
src/converter_sample_lane_packer.sv
verif/converter_sample_lane_packer_tb.sv
